### src/ber_pkg.sv
// Binary erosion ROI core: shared constants, types and helpers.
// Used by every module of the block; depends on nothing.
package ber_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_KERNEL = 7;
  localparam int LINES      = MAX_KERNEL - 1;
  localparam int WIN_BITS   = MAX_KERNEL * MAX_KERNEL;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int FW_W       = 11;
  localparam int CNT_W      = 13;
  localparam int SLOT_W     = 3;
  localparam logic [7:0] FULL_VALUE = 8'd255;

  localparam logic [2:0] CFG_MASK       = 3'd0;
  localparam logic [2:0] CFG_KSIZE      = 3'd1;
  localparam logic [2:0] CFG_FWIDTH     = 3'd2;
  localparam logic [2:0] CFG_ROW_START  = 3'd3;
  localparam logic [2:0] CFG_ROW_END    = 3'd4;
  localparam logic [2:0] CFG_COL_START  = 3'd5;
  localparam logic [2:0] CFG_COL_END    = 3'd6;

  typedef logic [LINES-1:0][7:0] line_word_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] mask;
    logic [2:0]          n;
    logic [1:0]          h;
    logic [FW_W-1:0]     w;
    logic [ROW_W-1:0]    row_start;
    logic [ROW_W:0]      row_end;
    logic [COL_W-1:0]    col_start;
    logic [COL_W:0]      col_end;
  } cfg_t;

  typedef struct packed {
    logic              push;
    logic              got;
    logic              last;
    logic              bypass;
    logic [7:0]        value;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] out_slot;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
  } stage_t;

  function automatic logic [2:0] eff_side(input logic [2:0] ks);
    logic [2:0] n;
    if (ks == 3'd0) begin
      n = 3'd1;
    end else if (!ks[0]) begin
      n = ks - 3'd1;
    end else begin
      n = ks;
    end
    return n;
  endfunction

  function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [FW_W-1:0] w;
    if (fw == '0) begin
      w = FW_W'(1);
    end else if (fw > FW_W'(MAX_WIDTH)) begin
      w = FW_W'(MAX_WIDTH);
    end else begin
      w = fw;
    end
    return w;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(LINES - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

### src/ber_line_mem.sv
// Line store: LINES byte lanes per column, two registered reads, lane write.
// Sweeps every column to zero after reset. Depends on ber_pkg.
module ber_line_mem import ber_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  output logic              clear_done,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_col,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_col_a,
  input  logic [COL_W-1:0]  rd_col_b,
  output line_word_t        rd_a,
  output line_word_t        rd_b
);

  line_word_t mem [MAX_WIDTH];
  logic [COL_W:0] clr_cnt_r;

  assign clear_done = clr_cnt_r[COL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clear_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clear_done) begin
      mem[clr_cnt_r[COL_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_col][wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[rd_col_a];
      rd_b <= mem[rd_col_b];
    end
  end

endmodule

### src/ber_seq.sv
// Input sequencer: frame, fill and drain counters, line store addressing,
// and the input stage register. Depends on ber_pkg.
module ber_seq import ber_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              advance,
  input  logic              in_action,
  input  logic [7:0]        in_pixel_value,
  input  logic              in_end_of_frame,
  input  logic [FW_W-1:0]   w,
  input  logic [CNT_W-1:0]  lag,
  output logic              wr_en,
  output logic [COL_W-1:0]  wr_col,
  output logic [SLOT_W-1:0] wr_slot,
  output logic [7:0]        wr_data,
  output logic [COL_W-1:0]  rd_col_out,
  output logic              st_valid_r,
  output stage_t            st_r
);

  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt, pend_r, pend_nxt;
  logic              ended_r, ended_nxt;
  stage_t            st_nxt;

  logic [ROW_W-1:0]  b_in_row, b_out_row;
  logic [COL_W-1:0]  b_in_col, b_out_col;
  logic [SLOT_W-1:0] b_in_slot, b_out_slot;
  logic [CNT_W-1:0]  b_fill;
  logic              restart, do_push, got, done;
  logic [7:0]        pv;

  always_comb begin
    restart   = !in_action && ended_r;
    b_in_row  = restart ? '0 : in_row_r;
    b_in_col  = restart ? '0 : in_col_r;
    b_in_slot = restart ? '0 : in_slot_r;
    b_out_row = restart ? '0 : out_row_r;
    b_out_col = restart ? '0 : out_col_r;
    b_out_slot = restart ? '0 : out_slot_r;
    b_fill    = restart ? '0 : fill_r;
    do_push   = !in_action || (ended_r && pend_r != '0);
    pv        = in_action ? 8'd0 : in_pixel_value;
    got       = do_push && (b_fill >= lag);

    in_row_nxt  = b_in_row;
    in_col_nxt  = b_in_col;
    in_slot_nxt = b_in_slot;
    out_row_nxt = b_out_row;
    out_col_nxt = b_out_col;
    out_slot_nxt = b_out_slot;
    fill_nxt    = b_fill;
    ended_nxt   = restart ? 1'b0 : ended_r;
    pend_nxt    = restart ? '0 : pend_r;
    done        = 1'b0;

    if (do_push) begin
      if (got) begin
        if ({1'b0, b_out_col} + 1'b1 >= w) begin
          out_col_nxt  = '0;
          out_slot_nxt = slot_inc(b_out_slot);
          out_row_nxt  = b_out_row + 1'b1;
        end else begin
          out_col_nxt = b_out_col + 1'b1;
        end
      end
      if ({1'b0, b_in_col} + 1'b1 >= w) begin
        in_col_nxt  = '0;
        in_slot_nxt = slot_inc(b_in_slot);
        in_row_nxt  = b_in_row + 1'b1;
      end else begin
        in_col_nxt = b_in_col + 1'b1;
      end
      if (b_fill < lag) begin
        fill_nxt = b_fill + 1'b1;
      end
    end

    if (!in_action && in_end_of_frame) begin
      if (lag == '0) begin
        done = 1'b1;
      end else begin
        ended_nxt = 1'b1;
        pend_nxt  = lag;
      end
    end else if (in_action && do_push) begin
      pend_nxt = pend_r - 1'b1;
      done     = (pend_nxt == '0);
    end

    if (done) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      in_slot_nxt = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      out_slot_nxt = '0;
      fill_nxt    = '0;
      pend_nxt    = '0;
      ended_nxt   = 1'b0;
    end

    st_nxt.push     = do_push;
    st_nxt.got      = got;
    st_nxt.last     = got && done;
    st_nxt.bypass   = (lag == '0);
    st_nxt.value    = pv;
    st_nxt.in_slot  = b_in_slot;
    st_nxt.out_slot = b_out_slot;
    st_nxt.out_row  = b_out_row;
    st_nxt.out_col  = b_out_col;
  end

  assign wr_en      = take && do_push;
  assign wr_col     = b_in_col;
  assign wr_slot    = b_in_slot;
  assign wr_data    = pv;
  assign rd_col_out = b_out_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      fill_r     <= '0;
      pend_r     <= '0;
      ended_r    <= 1'b0;
    end else if (take) begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_slot_r <= out_slot_nxt;
      fill_r     <= fill_nxt;
      pend_r     <= pend_nxt;
      ended_r    <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (!st_valid_r || advance) begin
      st_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st_r <= st_nxt;
    end
  end

endmodule

### src/ber_eval.sv
// Window register and erosion result for the word in the input stage.
// Depends on ber_pkg.
module ber_eval import ber_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  stage_t     st,
  input  cfg_t       cfg,
  input  line_word_t rd_in,
  input  line_word_t rd_out,
  output logic [7:0] res_value
);

  logic [WIN_BITS-1:0] win_r, win_nxt;
  logic [MAX_KERNEL-1:0] column;
  logic [SLOT_W:0] s;
  logic [7:0] orig;
  logic [11:0] r, c, rs, re, cs, ce, hh, ww;
  logic hit;
  int n, mbit, wbit;

  always_comb begin
    for (int j = 0; j < LINES; j++) begin
      s = {1'b0, st.in_slot} + (SLOT_W+1)'(j);
      if (s >= (SLOT_W+1)'(LINES)) begin
        s = s - (SLOT_W+1)'(LINES);
      end
      column[j] = (rd_in[s[SLOT_W-1:0]] != 8'd0);
    end
    column[LINES] = (st.value != 8'd0);
    win_nxt = (win_r >> MAX_KERNEL) |
              (WIN_BITS'(column) << (MAX_KERNEL * (MAX_KERNEL - 1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (step) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    n  = int'(cfg.n);
    hit = 1'b0;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
        mbit = a + b * n;
        wbit = (MAX_KERNEL - n + b) * MAX_KERNEL + (MAX_KERNEL - n + a);
        if (a < n && b < n) begin
          if (cfg.mask[mbit] && !win_nxt[wbit]) begin
            hit = 1'b1;
          end
        end
      end
    end

    orig = st.bypass ? st.value : rd_out[st.out_slot];
    r  = 12'(st.out_row);
    c  = 12'(st.out_col);
    rs = 12'(cfg.row_start);
    re = 12'(cfg.row_end);
    cs = 12'(cfg.col_start);
    ce = 12'(cfg.col_end);
    hh = 12'(cfg.h);
    ww = 12'(cfg.w);
    if (r < rs || r >= re || c < cs || c >= ce) begin
      res_value = orig;
    end else if (r < rs + hh || r + hh >= re || c < cs + hh || c + hh >= ce ||
                 c + hh >= ww) begin
      res_value = 8'd0;
    end else begin
      res_value = hit ? 8'd0 : FULL_VALUE;
    end
  end

endmodule

### src/binary_erosion_roi_core.sv
// Binary erosion over a region of interest, top level: config registers,
// handshakes and output register. Depends on ber_pkg, ber_line_mem, ber_seq, ber_eval.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_action, in_pixel_value, in_end_of_frame
//  out     | output    | out_valid / out_ready | out_value, out_row, out_col, out_last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per clock while the output is not stalled; a result passes the line store
// read into the input stage, then window evaluation into the output register.
// After reset the line store is swept to zero with in_ready low.
// Otherwise in_ready drops only while the input stage is full and the output register holds a result not yet taken.
module binary_erosion_roi_core import ber_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [7:0]          in_pixel_value,
  input  logic                in_end_of_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_value,
  output logic [ROW_W-1:0]    out_row,
  output logic [COL_W-1:0]    out_col,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [WIN_BITS-1:0] cfg_data
);

  logic [WIN_BITS-1:0] mask_r;
  logic [2:0]          ksize_r;
  logic [FW_W-1:0]     fwidth_r;
  logic [ROW_W-1:0]    row_start_r;
  logic [ROW_W:0]      row_end_r;
  logic [COL_W-1:0]    col_start_r;
  logic [COL_W:0]      col_end_r;

  cfg_t cfg;
  logic [CNT_W-1:0] lag, hw;
  logic clear_done, take, advance, st_valid_r, wr_en, out_valid_r;
  logic [COL_W-1:0]  wr_col, rd_col_out;
  logic [SLOT_W-1:0] wr_slot;
  logic [7:0] wr_data, res_value, out_value_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic out_last_r;
  line_word_t rd_in, rd_out;
  stage_t st_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '1;
      ksize_r     <= 3'd3;
      fwidth_r    <= FW_W'(640);
      row_start_r <= '0;
      row_end_r   <= (ROW_W+1)'(480);
      col_start_r <= '0;
      col_end_r   <= (COL_W+1)'(640);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MASK:      mask_r      <= cfg_data;
        CFG_KSIZE:     ksize_r     <= cfg_data[2:0];
        CFG_FWIDTH:    fwidth_r    <= cfg_data[FW_W-1:0];
        CFG_ROW_START: row_start_r <= cfg_data[ROW_W-1:0];
        CFG_ROW_END:   row_end_r   <= cfg_data[ROW_W:0];
        CFG_COL_START: col_start_r <= cfg_data[COL_W-1:0];
        CFG_COL_END:   col_end_r   <= cfg_data[COL_W:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mask      = mask_r;
    cfg.n         = eff_side(ksize_r);
    cfg.h         = cfg.n[2:1];
    cfg.w         = eff_width(fwidth_r);
    cfg.row_start = row_start_r;
    cfg.row_end   = row_end_r;
    cfg.col_start = col_start_r;
    cfg.col_end   = col_end_r;
    case (cfg.h)
      2'd0:    hw = '0;
      2'd1:    hw = CNT_W'(cfg.w);
      2'd2:    hw = CNT_W'(cfg.w) << 1;
      default: hw = CNT_W'(cfg.w) + (CNT_W'(cfg.w) << 1);
    endcase
    lag = hw + CNT_W'(cfg.h);
  end

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = clear_done && (!st_valid_r || advance);
  assign take     = in_valid && in_ready;

  ber_line_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_done (clear_done),
    .wr_en      (wr_en),
    .wr_col     (wr_col),
    .wr_slot    (wr_slot),
    .wr_data    (wr_data),
    .rd_en      (take),
    .rd_col_a   (wr_col),
    .rd_col_b   (rd_col_out),
    .rd_a       (rd_in),
    .rd_b       (rd_out)
  );

  ber_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .advance         (advance),
    .in_action       (in_action),
    .in_pixel_value  (in_pixel_value),
    .in_end_of_frame (in_end_of_frame),
    .w               (cfg.w),
    .lag             (lag),
    .wr_en           (wr_en),
    .wr_col          (wr_col),
    .wr_slot         (wr_slot),
    .wr_data         (wr_data),
    .rd_col_out      (rd_col_out),
    .st_valid_r      (st_valid_r),
    .st_r            (st_r)
  );

  ber_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (st_valid_r && advance && st_r.push),
    .st        (st_r),
    .cfg       (cfg),
    .rd_in     (rd_in),
    .rd_out    (rd_out),
    .res_value (res_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= st_valid_r && st_r.got;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && st_valid_r && st_r.got) begin
      out_value_r <= res_value;
      out_row_r   <= st_r.out_row;
      out_col_r   <= st_r.out_col;
      out_last_r  <= st_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule
